@@ rtl/dpr_pkg.sv @@
package dpr_pkg;

  localparam int LENGTH_BITS = 12;
  localparam int CNT_W = LENGTH_BITS;
  localparam int CFG_W = 12;
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = CFG_W'(511);

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ACK = 8'h2B;
  localparam logic [7:0] CH_NAK = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW = 2'd3;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic [2:0] n;
    result_t [MAX_RESULTS-1:0] ent;
  } batch_t;

  // bit 4 flags a non-hex character, bits 3..0 hold the digit value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    begin
      if (c >= 8'h61 && c <= 8'h66) begin
        v = {1'b0, 4'(c - 8'h57)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = {1'b0, 4'(c - 8'h37)};
      end else begin
        v = 5'h10;
      end
      return v;
    end
  endfunction

  function automatic batch_t push(input batch_t b, input logic [1:0] kind,
                                  input logic [7:0] data);
    batch_t r;
    begin
      r = b;
      if (b.n < 3'(MAX_RESULTS)) begin
        r.ent[b.n[1:0]].kind = kind;
        r.ent[b.n[1:0]].data = data;
        r.n = b.n + 3'd1;
      end
      return r;
    end
  endfunction

endpackage

@@ rtl/dpr_parser.sv @@
module dpr_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [dpr_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       step,
  input  logic [7:0]                 rx_byte,
  output dpr_pkg::batch_t            batch
);
  import dpr_pkg::*;

  logic [1:0]       phase, phase_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;
  logic [7:0]       held [3];
  logic [7:0]       held_next [3];
  logic             has_seq, has_seq_next;
  logic [4:0]       high_digit, high_digit_next;
  logic [CFG_W-1:0] max_payload;

  logic [CNT_W-1:0] cnt_inc;
  logic [LIM_W-1:0] lim, mp_ext, cnt_max_ext;
  logic [4:0]       hv;
  logic             sum_ok;

  assign cnt_inc = payload_count + CNT_W'(1);
  assign mp_ext = LIM_W'(max_payload);
  assign cnt_max_ext = LIM_W'({CNT_W{1'b1}});
  assign lim = (mp_ext > cnt_max_ext) ? cnt_max_ext : mp_ext;
  assign hv = hex_digit(rx_byte);
  assign sum_ok = !hv[4] && !high_digit[4] && ({high_digit[3:0], hv[3:0]} == running_sum);

  always_comb begin
    batch_t b;
    b = '0;
    phase_next = phase;
    running_sum_next = running_sum;
    payload_count_next = payload_count;
    held_next = held;
    has_seq_next = has_seq;
    high_digit_next = high_digit;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_START) begin
          phase_next = PH_PAYLOAD;
          running_sum_next = '0;
          payload_count_next = '0;
          has_seq_next = 1'b0;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_START) begin
          b = push(b, KIND_DISCARD, 8'h00);
          running_sum_next = '0;
          payload_count_next = '0;
          has_seq_next = 1'b0;
        end else if (rx_byte == CH_HASH) begin
          if (payload_count >= CNT_W'(1) && payload_count < CNT_W'(3)) begin
            b = push(b, KIND_PAYLOAD, held[0]);
          end
          if (payload_count == CNT_W'(2)) begin
            b = push(b, KIND_PAYLOAD, held[1]);
          end
          phase_next = PH_HIGH;
        end else begin
          running_sum_next = running_sum + rx_byte;
          if (payload_count < CNT_W'(2)) begin
            held_next[payload_count[1:0]] = rx_byte;
          end else if (payload_count == CNT_W'(2)) begin
            held_next[2] = rx_byte;
            if (rx_byte == CH_COLON) begin
              has_seq_next = 1'b1;
            end else begin
              b = push(b, KIND_PAYLOAD, held[0]);
              b = push(b, KIND_PAYLOAD, held[1]);
              b = push(b, KIND_PAYLOAD, rx_byte);
            end
          end else begin
            b = push(b, KIND_PAYLOAD, rx_byte);
          end
          payload_count_next = cnt_inc;
          if (LIM_W'(cnt_inc) >= lim) begin
            b = push(b, KIND_DISCARD, 8'h00);
            phase_next = PH_HUNT;
          end
        end
      end
      PH_HIGH: begin
        high_digit_next = hv;
        phase_next = PH_LOW;
      end
      default: begin
        if (sum_ok) begin
          b = push(b, KIND_REPLY, CH_ACK);
          if (has_seq) begin
            b = push(b, KIND_REPLY, held[0]);
            b = push(b, KIND_REPLY, held[1]);
          end
          b = push(b, KIND_ACCEPT, 8'h00);
        end else begin
          b = push(b, KIND_REPLY, CH_NAK);
          b = push(b, KIND_DISCARD, 8'h00);
        end
        phase_next = PH_HUNT;
      end
    endcase
    batch = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      running_sum <= '0;
      payload_count <= '0;
      has_seq <= 1'b0;
      high_digit <= '0;
      max_payload <= MAX_PAYLOAD_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_payload <= cfg_wr_data;
      end
      if (step) begin
        phase <= phase_next;
        running_sum <= running_sum_next;
        payload_count <= payload_count_next;
        has_seq <= has_seq_next;
        high_digit <= high_digit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held <= held_next;
    end
  end

endmodule

@@ rtl/dpr_out_buf.sv @@
module dpr_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  dpr_pkg::batch_t batch,
  output logic            can_load,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,  // data
  output logic [1:0]      m_tuser,  // kind
  output logic            m_tlast
);
  import dpr_pkg::*;

  logic [2:0]                    rem;
  result_t [MAX_RESULTS-1:0]     ent;
  logic                          pop;

  assign pop = m_tvalid && m_tready;
  assign m_tvalid = (rem != 3'd0);
  assign m_tdata = ent[0].data;
  assign m_tuser = ent[0].kind;
  assign m_tlast = (rem == 3'd1);
  assign can_load = (rem == 3'd0) || (rem == 3'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
    end else if (load) begin
      rem <= batch.n;
    end else if (pop) begin
      rem <= rem - 3'd1;
    end
  end

  // advance the queue head on each transaction
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= batch.ent;
    end else if (pop) begin
      ent <= {result_t'('0), ent[MAX_RESULTS-1:1]};
    end
  end

endmodule

@@ rtl/debug_packet_receiver_top.sv @@
// Remote-debug packet receiver: takes one received character per transaction
// on s_*, hunts for '$', forwards payload bytes, checks the two-digit hex
// checksum after '#', and answers with reply bytes ('+' plus, if the third
// payload byte is ':', an echoed two-byte sequence id; or '-'), then a verdict
// (accepted or discarded). One character yields zero to four results on m_*,
// the last one flagged by m_tlast. While m_tready is high, a character is
// taken every cycle if it yields at most one result, and one that yields
// more holds the input while the output queue drains them, one per cycle.
// An input register and the output queue let one character wait while results
// drain. Write max_payload through cfg_wr_en only while the block is idle.
module debug_packet_receiver_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [dpr_pkg::CFG_W-1:0] cfg_wr_data,  // max_payload
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,      // rx_byte
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,      // data
  output logic [1:0]                m_tuser,      // kind
  output logic                      m_tlast
);
  import dpr_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       can_load;
  logic       step;
  batch_t     batch;

  assign step = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  dpr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (in_byte),
    .batch       (batch)
  );

  dpr_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .batch    (batch),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
